>>> design/sfe_pkg.sv
package sfe_pkg;

  localparam int SampleBitsDef = 24;
  localparam int StoreDepthDef = 262144;
  localparam int LenBits       = 19;
  localparam int LenReset      = 48000;

  // per-cycle control shared by both channel lanes
  typedef struct packed {
    logic rd;   // request accepted, read the store at the ring pointer
    logic wr;   // write back the result of the request in flight
    logic fwd;  // request in flight read the entry while it was being written
    logic clr;  // clearing sweep owns the write port
  } sfe_lane_ctl_t;

endpackage

>>> design/stereo_feedback_echo.sv
// Stereo feedback echo. Each request on the input stream carries one stereo
// pair (left in the low bits of tdata, right above it); each channel has its
// own circular delay store with a shared ring pointer, and the block returns
// in + d/2 per channel and writes back (d + out)/2, with saturation. The delay
// length is set through cfg_we_i/cfg_wdata_i; the user must write it only
// while the block is idle, which it does not enforce. 0 acts as 1, values
// above the store depth act as the depth, and a shorter length restarts the
// pointer at 0 if it lies beyond it. Throughput is one request per clock
// cycle while the output queue has room, set by the single read and write
// ports of each channel's store, with a bypass for back-to-back hits on the
// same entry. The output stream is buffered in a three-entry queue. After
// reset the stores are cleared one entry per cycle, all STORE_DEPTH entries
// (262144 by default), with s_axis_tready_o low; config writes are taken.
module stereo_feedback_echo import sfe_pkg::*; #(
  parameter int STORE_DEPTH = StoreDepthDef,
  parameter int SAMPLE_BITS = SampleBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [SAMPLE_BITS-1:0] left_in, [2*SAMPLE_BITS-1:SAMPLE_BITS] right_in
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [SAMPLE_BITS-1:0] left_out, [2*SAMPLE_BITS-1:SAMPLE_BITS] right_out
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  input  logic                               cfg_we_i,
  input  logic [LenBits-1:0]                 cfg_wdata_i
);

  localparam int Aw   = $clog2(STORE_DEPTH);
  localparam int CmpW = (LenBits > Aw + 1) ? LenBits : Aw + 1;

  function automatic logic [CmpW-1:0] eff_len(input logic [LenBits-1:0] v);
    logic [CmpW-1:0] ext;
    ext = CmpW'(v);
    if (ext == '0) begin
      return CmpW'(1);
    end else if (ext > CmpW'(STORE_DEPTH)) begin
      return CmpW'(STORE_DEPTH);
    end else begin
      return ext;
    end
  endfunction

  logic [CmpW-1:0] len_q;
  logic [CmpW-1:0] new_len;
  logic [Aw-1:0]   ptr_q;
  logic [Aw:0]     ptr_inc;
  logic [Aw-1:0]   s1_addr_q;
  logic            s1_valid_q;
  logic            fwd_q;
  logic            clr_busy_q;
  logic [Aw-1:0]   clr_addr_q;
  logic            accept;
  logic            room;
  logic [Aw-1:0]   wr_addr;
  sfe_lane_ctl_t   ctl;
  logic [SAMPLE_BITS-1:0] left_out, right_out;

  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !clr_busy_q && room;
  assign new_len = eff_len(cfg_wdata_i);
  assign ptr_inc = {1'b0, ptr_q} + {{Aw{1'b0}}, 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= eff_len(LenBits'(LenReset));
      ptr_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_addr_q  <= '0;
      fwd_q      <= 1'b0;
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      if (cfg_we_i) begin
        len_q <= new_len;
        if (CmpW'(ptr_q) >= new_len) begin
          ptr_q <= '0;
        end
      end else if (accept) begin
        ptr_q <= (CmpW'(ptr_inc) >= len_q) ? '0 : ptr_inc[Aw-1:0];
      end
      s1_valid_q <= accept;
      if (accept) begin
        s1_addr_q <= ptr_q;
        fwd_q     <= s1_valid_q && (ptr_q == s1_addr_q);
      end
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + Aw'(1);
        if (clr_addr_q == Aw'(STORE_DEPTH - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    ctl.rd  = accept;
    ctl.wr  = s1_valid_q;
    ctl.fwd = fwd_q;
    ctl.clr = clr_busy_q;
  end

  assign wr_addr = clr_busy_q ? clr_addr_q : s1_addr_q;

  sfe_lane #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_lane_left (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .rd_addr_i (ptr_q),
    .wr_addr_i (wr_addr),
    .sample_i  (s_axis_tdata_i[SAMPLE_BITS-1:0]),
    .sample_o  (left_out)
  );

  sfe_lane #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_lane_right (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .rd_addr_i (ptr_q),
    .wr_addr_i (wr_addr),
    .sample_i  (s_axis_tdata_i[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .sample_o  (right_out)
  );

  sfe_merge #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s1_valid_q),
    .left_i          (left_out),
    .right_i         (right_out),
    .room_o          (room),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

>>> design/sfe_ram.sv
module sfe_ram #(
  parameter int Width = 26,
  parameter int Depth = 262144
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/sfe_lane.sv
module sfe_lane import sfe_pkg::*; #(
  parameter int SAMPLE_BITS = SampleBitsDef,
  parameter int STORE_DEPTH = StoreDepthDef
) (
  input  logic                           clk_i,
  input  sfe_lane_ctl_t                  ctl_i,
  input  logic [$clog2(STORE_DEPTH)-1:0] rd_addr_i,
  input  logic [$clog2(STORE_DEPTH)-1:0] wr_addr_i,
  input  logic signed [SAMPLE_BITS-1:0]  sample_i,
  output logic signed [SAMPLE_BITS-1:0]  sample_o
);

  localparam int Sw = SAMPLE_BITS;
  localparam int StW = SAMPLE_BITS + 2;

  logic [Sw-1:0]  sample_q;
  logic [StW-1:0] fwd_data_q;
  logic [StW-1:0] rdata;
  logic [StW-1:0] dly;
  logic [StW-1:0] sum;
  logic [Sw-1:0]  out_val;
  logic [StW:0]   tot;
  logic [StW-1:0] new_val;
  logic [StW-1:0] ram_wdata;
  logic [$clog2(STORE_DEPTH)-1:0] ram_waddr;
  logic           sum_ovf;

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      sample_q   <= sample_i;
      fwd_data_q <= new_val;
    end
  end

  // back-to-back hit on the same entry: memory still holds the old value
  assign dly = ctl_i.fwd ? fwd_data_q : rdata;

  // in + floor(d/2), saturated to the sample width
  assign sum     = {{2{sample_q[Sw-1]}}, sample_q} + {dly[StW-1], dly[StW-1:1]};
  assign sum_ovf = !((&sum[StW-1:Sw-1]) || !(|sum[StW-1:Sw-1]));
  always_comb begin
    if (sum_ovf) begin
      out_val = sum[StW-1] ? {1'b1, {(Sw-1){1'b0}}} : {1'b0, {(Sw-1){1'b1}}};
    end else begin
      out_val = sum[Sw-1:0];
    end
  end

  // floor((d + out)/2) always fits the store width
  assign tot     = {dly[StW-1], dly} + {{3{out_val[Sw-1]}}, out_val};
  assign new_val = tot[StW:1];

  assign ram_wdata = ctl_i.clr ? '0 : new_val;
  assign ram_waddr = wr_addr_i;

  sfe_ram #(
    .Width (StW),
    .Depth (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ctl_i.wr || ctl_i.clr),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ctl_i.rd),
    .raddr_i (rd_addr_i),
    .rdata_o (rdata)
  );

  assign sample_o = out_val;

endmodule

>>> design/sfe_merge.sv
module sfe_merge import sfe_pkg::*; #(
  parameter int SAMPLE_BITS = SampleBitsDef
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  input  logic [SAMPLE_BITS-1:0]                      left_i,
  input  logic [SAMPLE_BITS-1:0]                      right_i,
  output logic                                        room_o,
  output logic                                        m_axis_tvalid_o,
  input  logic                                        m_axis_tready_i,
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]          m_axis_tdata_o
);

  localparam int PairW = 2 * SAMPLE_BITS;
  localparam int DataW = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam logic [1:0] LastSlot = 2'd2;

  logic [PairW-1:0] buf_q [3];
  logic [1:0] wr_ptr_q, rd_ptr_q, cnt_q;
  logic pop;

  assign pop = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      buf_q[wr_ptr_q] <= {right_i, left_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (in_valid_i) begin
        wr_ptr_q <= (wr_ptr_q == LastSlot) ? 2'd0 : wr_ptr_q + 2'd1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastSlot) ? 2'd0 : rd_ptr_q + 2'd1;
      end
      cnt_q <= cnt_q + {1'b0, in_valid_i} - {1'b0, pop};
    end
  end

  // counts the request in the compute stage so a new one always finds a slot
  assign room_o = ({1'b0, cnt_q} + {2'b00, in_valid_i}) < 3'd3;

  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = DataW'(buf_q[rd_ptr_q]);

endmodule

>>> tb/stereo_feedback_echo_tb.sv
typedef struct packed {
  logic [23:0] right;
  logic [23:0] left;
} stereo_pair_t;

class echo_tracker;
  localparam int LenW = sfe_pkg::LenBits;

  int                             store_left[];
  int                             store_right[];
  int unsigned                    ring_ptr;
  logic [sfe_pkg::LenBits-1:0]    length_reg;
  stereo_pair_t                   expected_pairs[$];
  int                             mismatches;

  function new();
    store_left  = new[sfe_pkg::StoreDepthDef];
    store_right = new[sfe_pkg::StoreDepthDef];
    ring_ptr    = 0;
    length_reg  = LenW'(sfe_pkg::LenReset);
    mismatches  = 0;
  endfunction

  function longint sat(longint v, int w);
    longint hi = (longint'(1) << (w - 1)) - 1;
    longint lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // length in use: zero acts as one, anything beyond the store acts as its depth
  function int unsigned span();
    int unsigned n = 32'(length_reg);
    if (n == 0) n = 1;
    if (n > sfe_pkg::StoreDepthDef) n = sfe_pkg::StoreDepthDef;
    return n;
  endfunction

  function void write_length(logic [sfe_pkg::LenBits-1:0] v);
    length_reg = v;
    if (ring_ptr >= span()) ring_ptr = 0;
  endfunction

  // arithmetic shift gives the floor halving
  function logic [23:0] echo_lane(longint d, logic [23:0] raw, output longint fed_back);
    longint s_in = longint'($signed(raw));
    longint y = sat(s_in + (d >>> 1), sfe_pkg::SampleBitsDef);
    fed_back = sat((d + y) >>> 1, sfe_pkg::SampleBitsDef + 2);
    return y[23:0];
  endfunction

  function void take_input(logic [23:0] l_in, logic [23:0] r_in);
    int unsigned  n = span();
    int unsigned  idx = ring_ptr;
    longint       fb_l;
    longint       fb_r;
    stereo_pair_t want;
    if (idx >= n) idx = 0;
    want.left  = echo_lane(longint'(store_left[idx]), l_in, fb_l);
    want.right = echo_lane(longint'(store_right[idx]), r_in, fb_r);
    store_left[idx]  = int'(fb_l);
    store_right[idx] = int'(fb_r);
    idx++;
    if (idx >= n) idx = 0;
    ring_ptr = idx;
    expected_pairs.insert(expected_pairs.size(), want);
  endfunction

  function void check_output(stereo_pair_t got);
    stereo_pair_t want;
    if (expected_pairs.size() == 0) begin
      $error("unexpected result: left_out %0d right_out %0d",
             $signed(got.left), $signed(got.right));
      mismatches++;
      return;
    end
    want = expected_pairs.pop_front();
    if (got.left !== want.left) begin
      $error("left_out mismatch: expected %0d actual %0d",
             $signed(want.left), $signed(got.left));
      mismatches++;
    end
    if (got.right !== want.right) begin
      $error("right_out mismatch: expected %0d actual %0d",
             $signed(want.right), $signed(got.right));
      mismatches++;
    end
  endfunction

  function int pending();
    return expected_pairs.size();
  endfunction
endclass

module stereo_feedback_echo_tb;
  localparam int StallLimit = 800000;
  localparam int LenW       = sfe_pkg::LenBits;

  logic                        clk;
  logic                        rst_n = 1'b0;
  logic                        s_valid = 1'b0;
  logic                        s_ready;
  logic [47:0]                 s_data = '0;
  logic                        m_valid;
  logic                        m_ready = 1'b0;
  logic [47:0]                 m_data;
  logic                        cfg_we = 1'b0;
  logic [sfe_pkg::LenBits-1:0] cfg_wdata = '0;
  logic                        quiet = 1'b0;
  int                          stall_cycles = 0;
  echo_tracker                 tracker;

  stereo_feedback_echo u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial tracker = new();

  // handshake monitor and watchdog
  always @(posedge clk) begin
    if (cfg_we) tracker.write_length(cfg_wdata);
    if (s_valid && s_ready) tracker.take_input(s_data[23:0], s_data[47:24]);
    if (m_valid && m_ready) tracker.check_output(m_data);
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver backpressure
  initial begin
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (!quiet && ($urandom_range(0, 3) == 0)) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        m_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  task automatic send_pair(logic [23:0] l, logic [23:0] r);
    s_valid <= 1'b1;
    s_data  <= {r, l};
    do @(posedge clk); while (!s_ready);
  endtask

  task automatic pause(int unsigned n);
    s_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_length(logic [sfe_pkg::LenBits-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return {20'h00000, 4'($urandom)};
      3: return {20'hfffff, 4'($urandom)};
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    logic [sfe_pkg::LenBits-1:0] plan[$];
    int unsigned                 count;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset length, field extremes; the first request waits out the clearing sweep
    send_pair(24'h7fffff, 24'h800000);
    send_pair(24'h800000, 24'h7fffff);
    send_pair(24'h000000, 24'h000000);
    send_pair(24'hffffff, 24'h000001);
    send_pair(24'h000001, 24'hffffff);
    send_pair(24'h7fffff, 24'h7fffff);
    send_pair(24'h800000, 24'h800000);
    send_pair(24'h555555, 24'haaaaaa);
    drain();
    // pointer sits past the new length and restarts, then feedback saturates
    write_length(LenW'(1));
    repeat (6) send_pair(24'h7fffff, 24'h7fffff);
    repeat (6) send_pair(24'h800000, 24'h800000);
    drain();
    write_length(LenW'(0));
    repeat (4) send_pair(24'h800000, 24'h7fffff);
    drain();

    plan = {LenW'(2), LenW'(3), LenW'(524287), LenW'(262144), LenW'(1),
            LenW'($urandom_range(65, 4000)), LenW'(0),
            LenW'($urandom_range(1, 262144)), LenW'(17), LenW'(262143),
            LenW'(5), LenW'($urandom_range(4, 64))};

    foreach (plan[p]) begin
      write_length(plan[p]);
      if (p == plan.size() - 1) quiet = 1'b1;
      count = $urandom_range(100, 130);
      repeat (count) begin
        if (!quiet && ($urandom_range(0, 5) == 0)) pause($urandom_range(1, 19));
        send_pair(rand_sample(), rand_sample());
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
